@@ hdl/vws_pkg.sv @@
// ----------------------------------------------------------------------------
// Visible wavelength sampler package
// Shared widths, fixed-point constants, pipeline control and fill states.
// ----------------------------------------------------------------------------
package vws_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int ATANH_ENTRIES_DEF = 1024;
    localparam int LANES             = 4;
    localparam int PIPE_STAGES       = 11;

    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int V_W    = SAMPLE_BITS + 1;
    localparam int WL_W   = 18;
    localparam int DENS_W = 17;
    localparam int KNOT_W = 28;
    localparam int PROD_W = 25;
    localparam int TERM_W = 20;

    localparam int Q24_ONE = 16777216;

    localparam logic [24:0]       C_OFFSET         = 25'd14376396;
    localparam logic [24:0]       C_SLOPE          = 25'd30660362;
    localparam logic [30:0]       HALF_LN2_Q32     = 31'd1488522236;
    localparam logic [WL_W-1:0]   LAMBDA_CENTER_Q8 = 18'd137728;
    localparam logic [23:0]       LAMBDA_SCALE_Q16 = 24'd9102223;
    localparam logic [24:0]       INV_NORM_Q32     = 25'd16921330;
    localparam logic [SAMPLE_BITS-1:0] LANE_STEP_RESET = 16'd6554;
    localparam logic [DENS_W-1:0] DENS_MAX         = 17'd66100;
    localparam logic [31:0]       HALF_Q32         = 32'h8000_0000;
    localparam logic [23:0]       HALF_Q24         = 24'h80_0000;

    typedef enum logic [2:0] {
        FS_LOAD,
        FS_NORM,
        FS_SQR,
        FS_LOG,
        FS_MUL,
        FS_WRITE,
        FS_DONE
    } t_fill_state;

    typedef struct packed {
        logic [PIPE_STAGES:1] en;
    } t_pipe_ctl;

endpackage

@@ hdl/vws_sample_if.sv @@
// ----------------------------------------------------------------------------
// Sample channel
// One beat carries one uniform sample.
// ----------------------------------------------------------------------------
interface vws_sample_if
    import vws_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] u_sample;

    modport source (output valid, output u_sample, input ready);
    modport sink (input valid, input u_sample, output ready);
endinterface

@@ hdl/vws_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// One beat carries four wavelengths and their densities.
// ----------------------------------------------------------------------------
interface vws_result_if
    import vws_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WL_W-1:0]   wavelength0;
    logic [WL_W-1:0]   wavelength1;
    logic [WL_W-1:0]   wavelength2;
    logic [WL_W-1:0]   wavelength3;
    logic [DENS_W-1:0] density0;
    logic [DENS_W-1:0] density1;
    logic [DENS_W-1:0] density2;
    logic [DENS_W-1:0] density3;

    modport source (
        output valid, output wavelength0, output wavelength1, output wavelength2,
        output wavelength3, output density0, output density1, output density2,
        output density3, input ready
    );
    modport sink (
        input valid, input wavelength0, input wavelength1, input wavelength2,
        input wavelength3, input density0, input density1, input density2,
        input density3, output ready
    );
endinterface

@@ hdl/vws_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration channel
// One beat writes the lane step register.
// ----------------------------------------------------------------------------
interface vws_cfg_if
    import vws_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] lane_step;

    modport source (output valid, output lane_step, input ready);
    modport sink (input valid, input lane_step, output ready);
endinterface

@@ hdl/visible_wavelength_sampler.sv @@
// ----------------------------------------------------------------------------
// Visible wavelength sampler
// A result beat is valid once its sample beat has passed every pipeline stage.
// One sample beat is accepted per cycle while the first stage can load; the
// eleven-stage lane pipeline stalls stage by stage, so bubbles fill up while
// the result side waits. After reset the atanh table is built by a serial
// log2 unit; no sample is accepted until then, while lane step writes are
// accepted at all times.
// ----------------------------------------------------------------------------
module visible_wavelength_sampler
    import vws_pkg::*;
#(
    parameter int ATANH_TABLE_ENTRIES = ATANH_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vws_sample_if.sink    i_sample,
    vws_result_if.source  o_result,
    vws_cfg_if.sink       i_cfg
);

    localparam int AW = $clog2(ATANH_TABLE_ENTRIES + 1);

    logic [SAMPLE_BITS-1:0] r_lane_step;
    logic [PIPE_STAGES:1]   r_vld;
    logic [SUM_W-1:0]       r_sum [LANES];
    logic [SUM_W-1:0]       n_sum [LANES];
    t_pipe_ctl              w_ctl;
    logic                   w_fill_done;
    logic                   w_knot_we;
    logic [AW-1:0]          w_knot_waddr;
    logic [KNOT_W-1:0]      w_knot_wdata;
    logic [WL_W-1:0]        w_wl [LANES];
    logic [DENS_W-1:0]      w_dens [LANES];

    vws_knot_gen #(
        .ATANH_TABLE_ENTRIES (ATANH_TABLE_ENTRIES)
    ) u_knot_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_fill_done (w_fill_done),
        .o_we        (w_knot_we),
        .o_waddr     (w_knot_waddr),
        .o_wdata     (w_knot_wdata)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_step <= LANE_STEP_RESET;
        end else if (i_cfg.valid) begin
            r_lane_step <= i_cfg.lane_step;
        end
    end

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        w_ctl.en[PIPE_STAGES] = !r_vld[PIPE_STAGES] || o_result.ready;
        for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
    end

    assign i_sample.ready = w_fill_done && w_ctl.en[1];

    always_comb begin
        n_sum[0] = SUM_W'(i_sample.u_sample);
        n_sum[1] = SUM_W'(i_sample.u_sample) + SUM_W'(r_lane_step);
        n_sum[2] = SUM_W'(i_sample.u_sample) + (SUM_W'(r_lane_step) << 1);
        n_sum[3] = SUM_W'(i_sample.u_sample) + SUM_W'(r_lane_step)
                 + (SUM_W'(r_lane_step) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ctl.en[1]) begin
                r_vld[1] <= i_sample.valid && w_fill_done;
            end
            for (int k = 2; k <= PIPE_STAGES; k++) begin
                if (w_ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[1]) begin
            r_sum <= n_sum;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vws_lane #(
            .ATANH_TABLE_ENTRIES (ATANH_TABLE_ENTRIES)
        ) u_lane (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_sum        (r_sum[g]),
            .i_knot_we    (w_knot_we),
            .i_knot_waddr (w_knot_waddr),
            .i_knot_wdata (w_knot_wdata),
            .o_wavelength (w_wl[g]),
            .o_density    (w_dens[g])
        );
    end

    assign o_result.valid       = r_vld[PIPE_STAGES];
    assign o_result.wavelength0 = w_wl[0];
    assign o_result.wavelength1 = w_wl[1];
    assign o_result.wavelength2 = w_wl[2];
    assign o_result.wavelength3 = w_wl[3];
    assign o_result.density0    = w_dens[0];
    assign o_result.density1    = w_dens[1];
    assign o_result.density2    = w_dens[2];
    assign o_result.density3    = w_dens[3];

    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fill_done |-> !i_sample.ready)
        else $error("sample accepted while the atanh table is being built");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> r_vld[1])
        else $error("accepted sample beat did not enter the first stage");

    a_density_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.density0 <= DENS_MAX && o_result.density1 <= DENS_MAX
                         && o_result.density2 <= DENS_MAX && o_result.density3 <= DENS_MAX))
        else $error("density above its normalized maximum");

endmodule

@@ hdl/vws_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered, enabled read data.
// ----------------------------------------------------------------------------
module vws_ram
    import vws_pkg::*;
#(
    parameter int  WIDTH = KNOT_W,
    parameter int  DEPTH = ATANH_ENTRIES_DEF + 1,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ hdl/vws_knot_gen.sv @@
// ----------------------------------------------------------------------------
// Atanh knot generator
// Builds the atanh table after reset with a bit-serial log2 unit, one knot
// at a time, and writes each knot into the lane tables.
// ----------------------------------------------------------------------------
module vws_knot_gen
    import vws_pkg::*;
#(
    parameter int  ATANH_TABLE_ENTRIES = ATANH_ENTRIES_DEF,
    localparam int AW = $clog2(ATANH_TABLE_ENTRIES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_fill_done,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [KNOT_W-1:0] o_wdata
);

    localparam int XW = 25;
    localparam int RW = AW + 1;
    localparam logic [XW-1:0] X_STEP   = XW'(Q24_ONE / ATANH_TABLE_ENTRIES);
    localparam logic [RW-1:0] REM_STEP = RW'(Q24_ONE % ATANH_TABLE_ENTRIES);
    localparam logic [RW-1:0] REM_INIT = RW'(ATANH_TABLE_ENTRIES / 2);
    localparam logic [RW-1:0] REM_MOD  = RW'(ATANH_TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ATANH_TABLE_ENTRIES);

    t_fill_state       r_state;
    t_fill_state       n_state;
    logic [AW-1:0]     r_idx;
    logic [XW-1:0]     r_x;
    logic [RW-1:0]     r_rem;
    logic              r_second;
    logic [30:0]       r_m;
    logic [4:0]        r_p;
    logic [4:0]        r_iter;
    logic [31:0]       r_frac;
    logic [37:0]       r_log_a;
    logic [28:0]       r_du;
    logic [KNOT_W-1:0] r_knot;

    logic [30:0] w_operand;
    logic [61:0] w_sq;
    logic [31:0] w_t;
    logic [30:0] n_m;
    logic [5:0]  w_exp;
    logic [37:0] w_log;
    logic [38:0] w_d;
    logic [37:0] w_du_sum;
    logic [28:0] n_du;
    logic [60:0] w_kp;
    logic [RW-1:0] w_rem_sum;
    logic [RW-1:0] n_rem;
    logic [XW-1:0] n_x;

    always_comb begin
        if (r_second) begin
            if (r_x >= XW'(Q24_ONE)) begin
                w_operand = 31'd1;
            end else begin
                w_operand = 31'(XW'(Q24_ONE) - r_x);
            end
        end else begin
            w_operand = 31'(Q24_ONE) + 31'(r_x);
        end
    end

    assign w_sq = 62'(r_m) * 62'(r_m);
    assign w_t  = w_sq[61:30];
    assign n_m  = w_t[31] ? w_t[31:1] : w_t[30:0];

    assign w_exp    = 6'(r_p) - 6'd24;
    assign w_log    = {w_exp, r_frac};
    assign w_d      = {r_log_a[37], r_log_a} - {w_log[37], w_log};
    assign w_du_sum = {1'b0, w_d[36:0]} + 38'd128;
    assign n_du     = w_d[38] ? '0 : w_du_sum[36:8];
    assign w_kp     = 61'(r_du) * 61'(HALF_LN2_Q32) + 61'(HALF_Q32);

    always_comb begin
        w_rem_sum = r_rem + REM_STEP;
        if (w_rem_sum >= REM_MOD) begin
            n_rem = w_rem_sum - REM_MOD;
            n_x   = r_x + X_STEP + XW'(1);
        end else begin
            n_rem = w_rem_sum;
            n_x   = r_x + X_STEP;
        end
    end

    always_comb begin
        case (r_state)
            FS_LOAD:  n_state = FS_NORM;
            FS_NORM:  n_state = r_m[30] ? FS_SQR : FS_NORM;
            FS_SQR:   n_state = (r_iter == 5'd31) ? FS_LOG : FS_SQR;
            FS_LOG:   n_state = r_second ? FS_MUL : FS_LOAD;
            FS_MUL:   n_state = FS_WRITE;
            FS_WRITE: n_state = (r_idx == LAST_IDX) ? FS_DONE : FS_LOAD;
            FS_DONE:  n_state = FS_DONE;
            default:  n_state = FS_LOAD;
        endcase
    end

    always_comb begin
        o_we        = (r_state == FS_WRITE);
        o_fill_done = (r_state == FS_DONE);
    end

    assign o_waddr = r_idx;
    assign o_wdata = r_knot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_LOAD;
            r_idx    <= '0;
            r_x      <= '0;
            r_rem    <= REM_INIT;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                FS_LOG: begin
                    if (!r_second) begin
                        r_second <= 1'b1;
                    end
                end
                FS_WRITE: begin
                    if (r_idx != LAST_IDX) begin
                        r_idx    <= r_idx + AW'(1);
                        r_x      <= n_x;
                        r_rem    <= n_rem;
                        r_second <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_LOAD: begin
                r_m <= w_operand;
                r_p <= 5'd30;
            end
            FS_NORM: begin
                if (r_m[30]) begin
                    r_iter <= '0;
                end else begin
                    r_m <= {r_m[29:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end
            end
            FS_SQR: begin
                r_m    <= n_m;
                r_frac <= {r_frac[30:0], w_t[31]};
                r_iter <= r_iter + 5'd1;
            end
            FS_LOG: begin
                if (r_second) begin
                    r_du <= n_du;
                end else begin
                    r_log_a <= w_log;
                end
            end
            FS_MUL: begin
                r_knot <= w_kp[32 +: KNOT_W];
            end
            default: begin
            end
        endcase
    end

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_DONE) |=> (r_state == FS_DONE))
        else $error("knot generator left the done state");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_SQR) |-> r_m[30])
        else $error("log2 mantissa is not normalized while squaring");

    a_next_knot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_WRITE && r_idx != LAST_IDX) |=> (r_state == FS_LOAD && !r_second))
        else $error("knot generator did not restart on the next knot");

endmodule

@@ hdl/vws_lane.sv @@
// ----------------------------------------------------------------------------
// Wavelength lane
// Wraps one lane sample, maps it through the interpolated atanh table to a
// wavelength and computes its density, over pipeline stages two to eleven.
// ----------------------------------------------------------------------------
module vws_lane
    import vws_pkg::*;
#(
    parameter int  ATANH_TABLE_ENTRIES = ATANH_ENTRIES_DEF,
    localparam int AW = $clog2(ATANH_TABLE_ENTRIES + 1)
) (
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic              i_knot_we,
    input  logic [AW-1:0]     i_knot_waddr,
    input  logic [KNOT_W-1:0] i_knot_wdata,
    output logic [WL_W-1:0]   o_wavelength,
    output logic [DENS_W-1:0] o_density
);

    localparam int POS_W = 24 + AW;
    localparam int PF_W  = V_W + PROD_W + 1;
    localparam logic [SUM_W-1:0] ONE_S   = SUM_W'(1) << SAMPLE_BITS;
    localparam logic [V_W-1:0]   ONE_V   = V_W'(1) << SAMPLE_BITS;
    localparam logic [PF_W-1:0]  ROUND_S = PF_W'(1) << (SAMPLE_BITS - 1);

    logic [V_W-1:0]    r2_v;
    logic [PROD_W-1:0] r3_prod;
    logic [23:0]       r4_a;
    logic              r4_neg;
    logic [AW-1:0]     r5_idx;
    logic [23:0]       r5_frac;
    logic [23:0]       r5_sq;
    logic              r5_neg;
    logic [23:0]       r6_frac;
    logic              r6_neg;
    logic [DENS_W-1:0] r6_dens;
    logic [KNOT_W-1:0] r7_t0;
    logic [KNOT_W-1:0] r7_diff;
    logic [23:0]       r7_frac;
    logic              r7_neg;
    logic [DENS_W-1:0] r7_dens;
    logic [KNOT_W-1:0] r8_t0;
    logic [KNOT_W-1:0] r8_step;
    logic              r8_neg;
    logic [DENS_W-1:0] r8_dens;
    logic [KNOT_W-1:0] r9_at;
    logic              r9_neg;
    logic [DENS_W-1:0] r9_dens;
    logic [TERM_W-1:0] r10_term;
    logic              r10_neg;
    logic [DENS_W-1:0] r10_dens;
    logic [WL_W-1:0]   r11_wl;
    logic [DENS_W-1:0] r11_dens;

    logic [SUM_W-1:0]  w_wrap;
    logic [V_W-1:0]    n_v;
    logic [PF_W-1:0]   w_prod_full;
    logic [25:0]       w_x;
    logic [25:0]       w_mag;
    logic [23:0]       n_a;
    logic [POS_W-1:0]  w_pos;
    logic [48:0]       w_sqf;
    logic [24:0]       w_om;
    logic [50:0]       w_df;
    logic [KNOT_W-1:0] w_t0;
    logic [KNOT_W-1:0] w_t1;
    logic [52:0]       w_mix;
    logic [52:0]       w_tf;
    logic [20:0]       w_lam_hi;
    logic [WL_W-1:0]   n_wl;

    always_comb begin
        w_wrap = (i_sum > ONE_S) ? (i_sum - ONE_S) : i_sum;
        n_v    = (w_wrap > ONE_S) ? ONE_V : w_wrap[V_W-1:0];
    end

    assign w_prod_full = PF_W'(r2_v) * PF_W'(C_SLOPE) + ROUND_S;

    always_comb begin
        w_x   = {1'b0, C_OFFSET} - {1'b0, r3_prod};
        w_mag = w_x[25] ? (26'd0 - w_x) : w_x;
        n_a   = (w_mag >= 26'(Q24_ONE)) ? 24'hFF_FFFF : w_mag[23:0];
    end

    assign w_pos = POS_W'(r4_a) * POS_W'(ATANH_TABLE_ENTRIES);
    assign w_sqf = 49'(r4_a) * 49'(r4_a) + 49'(HALF_Q24);

    assign w_om = 25'(Q24_ONE) - 25'(r5_sq);
    assign w_df = 51'(w_om) * 51'(INV_NORM_Q32) + 51'(HALF_Q32);

    vws_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (ATANH_TABLE_ENTRIES + 1)
    ) u_knots (
        .i_clk    (i_clk),
        .i_we     (i_knot_we),
        .i_waddr  (i_knot_waddr),
        .i_wdata  (i_knot_wdata),
        .i_re     (i_ctl.en[6]),
        .i_raddr0 (r5_idx),
        .i_raddr1 (r5_idx + AW'(1)),
        .o_rdata0 (w_t0),
        .o_rdata1 (w_t1)
    );

    assign w_mix = 53'(r7_diff) * 53'(r7_frac) + 53'(HALF_Q24);
    assign w_tf  = 53'(r9_at) * 53'(LAMBDA_SCALE_Q16) + 53'(HALF_Q32);

    always_comb begin
        w_lam_hi = 21'(LAMBDA_CENTER_Q8) + 21'(r10_term);
        if (r10_neg) begin
            n_wl = (w_lam_hi > 21'h3_FFFF) ? 18'h3_FFFF : w_lam_hi[WL_W-1:0];
        end else if (20'(LAMBDA_CENTER_Q8) < r10_term) begin
            n_wl = '0;
        end else begin
            n_wl = LAMBDA_CENTER_Q8 - WL_W'(r10_term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r2_v <= n_v;
        end
        if (i_ctl.en[3]) begin
            r3_prod <= w_prod_full[SAMPLE_BITS +: PROD_W];
        end
        if (i_ctl.en[4]) begin
            r4_a   <= n_a;
            r4_neg <= w_x[25];
        end
        if (i_ctl.en[5]) begin
            r5_idx  <= w_pos[24 +: AW];
            r5_frac <= w_pos[23:0];
            r5_sq   <= w_sqf[24 +: 24];
            r5_neg  <= r4_neg;
        end
        if (i_ctl.en[6]) begin
            r6_frac <= r5_frac;
            r6_neg  <= r5_neg;
            r6_dens <= w_df[32 +: DENS_W];
        end
        if (i_ctl.en[7]) begin
            r7_t0   <= w_t0;
            r7_diff <= (w_t1 < w_t0) ? '0 : (w_t1 - w_t0);
            r7_frac <= r6_frac;
            r7_neg  <= r6_neg;
            r7_dens <= r6_dens;
        end
        if (i_ctl.en[8]) begin
            r8_t0   <= r7_t0;
            r8_step <= w_mix[24 +: KNOT_W];
            r8_neg  <= r7_neg;
            r8_dens <= r7_dens;
        end
        if (i_ctl.en[9]) begin
            r9_at   <= r8_t0 + r8_step;
            r9_neg  <= r8_neg;
            r9_dens <= r8_dens;
        end
        if (i_ctl.en[10]) begin
            r10_term <= w_tf[32 +: TERM_W];
            r10_neg  <= r9_neg;
            r10_dens <= r9_dens;
        end
        if (i_ctl.en[11]) begin
            r11_wl   <= n_wl;
            r11_dens <= r10_dens;
        end
    end

    assign o_wavelength = r11_wl;
    assign o_density    = r11_dens;

endmodule

@@ tb/visible_wavelength_sampler_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visible wavelength sampler testbench
// Drives uniform samples and lane step writes through the handshake channels,
// with random gaps on both sides and one long hold on the result side. A
// scoreboard predicts the four wavelengths and densities of every accepted
// sample in fixed point and compares each result beat against them in order.
// ----------------------------------------------------------------------------
module visible_wavelength_sampler_test;
    import vws_pkg::*;

    typedef logic [63:0] t_u64;

    typedef struct packed {
        logic [LANES-1:0][WL_W-1:0]   wl;
        logic [LANES-1:0][DENS_W-1:0] dens;
    } t_spectrum;

    localparam t_u64 SAMPLE_ONE       = t_u64'(1) << SAMPLE_BITS;
    localparam t_u64 Q24              = t_u64'(Q24_ONE);
    localparam int   KNOTS            = ATANH_ENTRIES_DEF;
    localparam int   WATCHDOG_LIMIT   = 500_000;
    localparam int   HOLD_CYCLES      = 64;
    localparam int   RANDOM_PER_PHASE = 100;
    localparam int   RANDOM_PHASES    = 8;

    class t_spectrum_board;
        t_u64                   knots[KNOTS + 1];
        logic [SAMPLE_BITS-1:0] stride;
        t_spectrum              owed[$];
        int                     errors;

        function new();
            t_u64   x, lo, du;
            longint d;
            stride = LANE_STEP_RESET;
            errors = 0;
            for (int i = 0; i <= KNOTS; i++) begin
                x  = (t_u64'(i) * Q24 + KNOTS / 2) / KNOTS;
                lo = (x >= Q24) ? t_u64'(1) : Q24 - x;
                d  = log2_q24(Q24 + x) - log2_q24(lo);
                du = (d > 0) ? t_u64'(d) : t_u64'(0);
                du = (du + 128) >> 8;
                knots[i] = (du * HALF_LN2_Q32 + HALF_Q32) >> 32;
            end
        endfunction

        // Returns log2 of a Q.24 value as signed Q.32.
        function longint log2_q24(t_u64 a);
            int   p;
            t_u64 m, frac;
            if (a == 0) a = 1;
            p = 63;
            while (p > 0 && a[p] == 1'b0) p--;
            m    = (p >= 30) ? (a >> (p - 30)) : (a << (30 - p));
            frac = 0;
            for (int i = 0; i < 32; i++) begin
                m = (m * m) >> 30;
                if (m >= 64'h8000_0000) begin
                    m = m >> 1;
                    frac[31 - i] = 1'b1;
                end
            end
            return longint'(p - 24) * 64'sd4294967296 + longint'(frac);
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] u);
            t_u64      v, prod, mag, pos, idx, frac, t0, t1, at, term, sq, om;
            longint    x, lam;
            bit        neg;
            t_spectrum want;
            for (int k = 0; k < LANES; k++) begin
                v = t_u64'(u) + t_u64'(k) * t_u64'(stride);
                if (v > SAMPLE_ONE) v = v - SAMPLE_ONE;
                if (v > SAMPLE_ONE) v = SAMPLE_ONE;
                prod = (v * C_SLOPE + (t_u64'(1) << (SAMPLE_BITS - 1))) >> SAMPLE_BITS;
                x    = longint'(C_OFFSET) - longint'(prod);
                neg  = (x < 0);
                mag  = neg ? t_u64'(-x) : t_u64'(x);
                if (mag >= Q24) mag = Q24 - 1;
                pos  = mag * KNOTS;
                idx  = pos >> 24;
                frac = pos & (Q24 - 1);
                if (idx >= KNOTS) begin
                    at = knots[KNOTS];
                end else begin
                    t0 = knots[idx];
                    t1 = knots[idx + 1];
                    if (t1 < t0) t1 = t0;
                    at = t0 + (((t1 - t0) * frac + HALF_Q24) >> 24);
                end
                term = (at * LAMBDA_SCALE_Q16 + HALF_Q32) >> 32;
                lam  = neg ? longint'(LAMBDA_CENTER_Q8) + longint'(term)
                           : longint'(LAMBDA_CENTER_Q8) - longint'(term);
                if (lam < 0) lam = 0;
                if (lam > 262143) lam = 262143;
                want.wl[k] = WL_W'(lam);
                sq = (mag * mag + HALF_Q24) >> 24;
                om = (sq >= Q24) ? t_u64'(0) : Q24 - sq;
                want.dens[k] = DENS_W'((om * INV_NORM_Q32 + HALF_Q32) >> 32);
            end
            owed.push_back(want);
        endfunction

        function void check_beat(t_spectrum got);
            t_spectrum want;
            if (owed.size() == 0) begin
                $error("result beat arrived with no sample outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            for (int k = 0; k < LANES; k++) begin
                if (got.wl[k] !== want.wl[k]) begin
                    $error("wavelength%0d: expected %0d, got %0d", k, want.wl[k], got.wl[k]);
                    errors++;
                end
                if (got.dens[k] !== want.dens[k]) begin
                    $error("density%0d: expected %0d, got %0d", k, want.dens[k], got.dens[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    t_spectrum_board board;
    t_spectrum       seen;
    int              quiet_cycles = 0;
    bit              tx_idle      = 1'b1;
    bit              rx_idle      = 1'b1;
    bit              hold_result  = 1'b0;

    vws_sample_if smp ();
    vws_result_if res ();
    vws_cfg_if    cfg ();

    visible_wavelength_sampler i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_result (res),
        .i_cfg    (cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Samples favor the extremes and values that put a lane exactly on 1.0.
    function automatic logic [SAMPLE_BITS-1:0] random_sample(logic [SAMPLE_BITS-1:0] stride);
        int pick, target;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return SAMPLE_BITS'(1);
                default: return SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            endcase
        end
        target = (1 << SAMPLE_BITS) - int'($urandom_range(1, 3)) * int'(stride);
        if (pick == 1 && target >= 0 && target < (1 << SAMPLE_BITS)) begin
            return SAMPLE_BITS'(target);
        end
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] u);
        int gap;
        gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid    <= 1'b1;
        smp.u_sample <= u;
        do @(posedge i_clk); while (smp.ready !== 1'b1);
        board.note_sample(u);
    endtask

    task automatic write_lane_step(input logic [SAMPLE_BITS-1:0] stride);
        cfg.valid     <= 1'b1;
        cfg.lane_step <= stride;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        cfg.valid    <= 1'b0;
        board.stride = stride;
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int pause;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_result) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_result = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                pause = pick_gap();
                res.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (res.valid === 1'b1 && res.ready === 1'b1) begin
            seen.wl   = {res.wavelength3, res.wavelength2, res.wavelength1, res.wavelength0};
            seen.dens = {res.density3, res.density2, res.density1, res.density0};
            board.check_beat(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
            (res.valid === 1'b1 && res.ready === 1'b1) ||
            (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [SAMPLE_BITS-1:0] strides[RANDOM_PHASES];
        board = new();
        smp.valid     <= 1'b0;
        smp.u_sample  <= '0;
        cfg.valid     <= 1'b0;
        cfg.lane_step <= '0;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset stride puts lane 3 on 1.0 for 45874 and lane 1 for 58982.
        send_sample(16'd0);     send_sample(16'd65535); send_sample(16'd1);
        send_sample(16'd32768); send_sample(16'd45874); send_sample(16'd58982);
        send_sample(16'd21845); send_sample(16'd43690);

        // With the largest stride the upper lanes wrap once and lane 3 always saturates.
        wait_drained();
        write_lane_step(16'd65535);
        send_sample(16'd0);     send_sample(16'd2);
        send_sample(16'd65535); send_sample(16'd32768);

        wait_drained();
        write_lane_step(16'd0);
        send_sample(16'd0); send_sample(16'd65535); send_sample(16'd12345);

        wait_drained();
        write_lane_step(16'd16384);
        send_sample(16'd16384); send_sample(16'd0); send_sample(16'd49152);

        wait_drained();
        write_lane_step(16'd32768);
        send_sample(16'd65535); send_sample(16'd32769);

        strides[0] = SAMPLE_BITS'($urandom_range(0, 65535));
        strides[1] = 16'd0;
        strides[2] = 16'd65535;
        strides[3] = LANE_STEP_RESET;
        strides[4] = 16'd21845;
        strides[5] = SAMPLE_BITS'($urandom_range(1, 200));
        strides[6] = 16'd32768;
        strides[7] = SAMPLE_BITS'($urandom_range(0, 65535));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            write_lane_step(strides[ph]);
            // In phase 2 the result side holds off while samples keep coming.
            tx_idle     = (ph % 4 != 3) && (ph != 2);
            rx_idle     = (ph % 4 != 3);
            hold_result = (ph == 2);
            repeat (RANDOM_PER_PHASE) send_sample(random_sample(strides[ph]));
        end

        wait_drained();
        repeat (PIPE_STAGES + 10) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
